// File: src/rgb_led_bit_pulse_encoder_top_assert.svh
// ----------------------------------------------------------------------------
// RGB LED bit pulse encoder assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_BIT_PULSE_ENCODER_TOP_ASSERT_SVH
`define RGB_LED_BIT_PULSE_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define RLBPE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlbpe same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define RLBPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlbpe next-cycle check failed");
`else
`define RLBPE_ASSERT_SAME(label, clk, rst, ante, cons)
`define RLBPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/rlbpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED bit pulse encoder package
// Widths, register indexes, reset values and the types shared by the modules.
// ----------------------------------------------------------------------------
package rlbpe_pkg;

   localparam int CHAN_W     = 8;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_LANES  = 3;
   localparam int PIXEL_BITS = NUM_LANES * CHAN_W;
   localparam int COUNT_W    = $clog2(PIXEL_BITS + 1);
   localparam int STEP_W     = $clog2(CHAN_W);

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CFG_IDX_DIVISOR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_IDX_ONE_HIGH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_IDX_ONE_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_IDX_ZERO_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_IDX_ZERO_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_IDX_LATCH     = 3'd5;

   // Register reset values.
   localparam logic [CHAN_W-1:0] RST_DIVISOR   = 8'd1;
   localparam logic [TICK_W-1:0] RST_ONE_HIGH  = 16'd56;
   localparam logic [TICK_W-1:0] RST_ONE_LOW   = 16'd48;
   localparam logic [TICK_W-1:0] RST_ZERO_HIGH = 16'd18;
   localparam logic [TICK_W-1:0] RST_ZERO_LOW  = 16'd48;
   localparam logic [TICK_W-1:0] RST_LATCH     = 16'd4000;

   // Operation codes of an input word.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_LATCH = 1'b1;

   typedef struct packed {
      logic [TICK_W-1:0] one_high;
      logic [TICK_W-1:0] one_low;
      logic [TICK_W-1:0] zero_high;
      logic [TICK_W-1:0] zero_low;
      logic [TICK_W-1:0] latch;
   } tick_cfg_type;

   typedef struct packed {
      logic start;
      logic take;
   } lane_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } lane_stat_type;

   typedef struct packed {
      logic               active;
      logic               load_ready;
      logic [COUNT_W-1:0] left;
   } merge_stat_type;

endpackage

// File: src/rlbpe_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLBPE divider lane
// Restoring divider for one color channel, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlbpe_div_lane
   import rlbpe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  lane_ctl_type      ctl,
   input  logic [CHAN_W-1:0] dividend,
   input  logic [CHAN_W-1:0] divisor,
   output lane_stat_type     stat,
   output logic [CHAN_W-1:0] quotient
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CHAN_W-1:0] rem_ff, rem_in;
   logic [CHAN_W-1:0] quot_ff, quot_in;
   logic [CHAN_W-1:0] div_ff, div_in;

   logic [CHAN_W:0]   trial;
   logic [CHAN_W+1:0] diff;
   logic              fits;

   assign trial = {rem_ff, quot_ff[CHAN_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, div_ff};
   assign fits  = !diff[CHAN_W+1];

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      if (ctl.start) begin
         state_in = ST_RUN;
         step_in  = '0;
         rem_in   = '0;
         quot_in  = dividend;
         // A zero divisor behaves as one.
         div_in   = (divisor == '0) ? CHAN_W'(1) : divisor;
      end else begin
         unique case (state_ff)
            ST_RUN: begin
               rem_in  = fits ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
               quot_in = {quot_ff[CHAN_W-2:0], fits};
               step_in = step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(CHAN_W - 1)) begin
                  state_in = ST_DONE;
               end
            end
            ST_DONE: begin
               if (ctl.take) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_DONE);
   assign quotient  = quot_ff;

endmodule

// File: src/rlbpe_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RLBPE merge and serializer
// Takes the 24-bit word of lane quotients and sends it out as pulses, or one latch pulse.
// ----------------------------------------------------------------------------
module rlbpe_merge
   import rlbpe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  load_op,
   input  logic [PIXEL_BITS-1:0] load_word,
   input  tick_cfg_type          ticks,
   output merge_stat_type        stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TICK_W-1:0]     rsp_high_ticks,
   output logic [TICK_W-1:0]     rsp_low_ticks,
   output logic                  rsp_last
);

   logic                  active_ff, active_in;
   logic                  latch_ff, latch_in;
   logic [COUNT_W-1:0]    left_ff, left_in;
   logic [PIXEL_BITS-1:0] shift_ff, shift_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TICK_W-1:0]     rsp_high_ff, rsp_high_in;
   logic [TICK_W-1:0]     rsp_low_ff, rsp_low_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic out_free;
   logic emit;
   logic final_pulse;
   logic bit_val;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign emit        = active_ff && out_free;
   assign final_pulse = latch_ff || (left_ff == COUNT_W'(1));
   assign bit_val     = shift_ff[PIXEL_BITS-1];

   always_comb begin
      active_in    = active_ff;
      latch_in     = latch_ff;
      left_in      = left_ff;
      shift_in     = shift_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = final_pulse;
         if (latch_ff) begin
            rsp_high_in = '0;
            rsp_low_in  = ticks.latch;
         end else begin
            rsp_high_in = bit_val ? ticks.one_high : ticks.zero_high;
            rsp_low_in  = bit_val ? ticks.one_low : ticks.zero_low;
         end
         shift_in = {shift_ff[PIXEL_BITS-2:0], 1'b0};
         left_in  = left_ff - COUNT_W'(1);
         if (final_pulse) begin
            active_in = 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      // A new word may load in the cycle the previous one sends its last pulse.
      if (load) begin
         active_in = 1'b1;
         latch_in  = load_op;
         shift_in  = load_word;
         left_in   = COUNT_W'(PIXEL_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      latch_ff    <= latch_in;
      left_ff     <= left_in;
      shift_ff    <= shift_in;
      rsp_high_ff <= rsp_high_in;
      rsp_low_ff  <= rsp_low_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign stat.active     = active_ff;
   assign stat.load_ready = !active_ff || (emit && final_pulse);
   assign stat.left       = left_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_high_ticks = rsp_high_ff;
   assign rsp_low_ticks  = rsp_low_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: src/rgb_led_bit_pulse_encoder_top.sv
`timescale 1ns / 1ps
// A pixel word is divided by the brightness divisor in three divider lanes
// (green, red, blue), then sent as 24 pulse words, one per cycle while
// rsp_ready is high, most significant bit of green first; a latch word gives a
// single pulse word. Division of the next pixel overlaps the serialization of
// the current one: the lanes take a new pixel while the current one is still
// being sent. Pulse words leave through a registered output.
// ----------------------------------------------------------------------------
// RGB LED bit pulse encoder top level
// Configuration registers, input stage, divider lanes and pulse serializer.
// ----------------------------------------------------------------------------
`include "rgb_led_bit_pulse_encoder_top_assert.svh"

module rgb_led_bit_pulse_encoder_top
   import rlbpe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [CHAN_W-1:0]    req_red,
   input  logic [CHAN_W-1:0]    req_green,
   input  logic [CHAN_W-1:0]    req_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [TICK_W-1:0]    rsp_high_ticks,
   output logic [TICK_W-1:0]    rsp_low_ticks,
   output logic                 rsp_last
);

   logic [CHAN_W-1:0] divisor_ff, divisor_in;
   tick_cfg_type      ticks_ff, ticks_in;

   logic front_valid_ff, front_valid_in;
   logic front_op_ff, front_op_in;

   lane_ctl_type      lane_ctl;
   lane_stat_type     lane_stat [NUM_LANES];
   logic [CHAN_W-1:0] lane_in [NUM_LANES];
   logic [CHAN_W-1:0] lane_q [NUM_LANES];
   logic [NUM_LANES-1:0] lane_done;

   merge_stat_type        merge_stat;
   logic [PIXEL_BITS-1:0] merge_word;

   logic req_fire;
   logic front_ready;
   logic front_take;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      divisor_in = divisor_ff;
      ticks_in   = ticks_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CFG_IDX_DIVISOR:   divisor_in         = csr_wdata[CHAN_W-1:0];
            CFG_IDX_ONE_HIGH:  ticks_in.one_high  = csr_wdata;
            CFG_IDX_ONE_LOW:   ticks_in.one_low   = csr_wdata;
            CFG_IDX_ZERO_HIGH: ticks_in.zero_high = csr_wdata;
            CFG_IDX_ZERO_LOW:  ticks_in.zero_low  = csr_wdata;
            CFG_IDX_LATCH:     ticks_in.latch     = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff         <= RST_DIVISOR;
         ticks_ff.one_high  <= RST_ONE_HIGH;
         ticks_ff.one_low   <= RST_ONE_LOW;
         ticks_ff.zero_high <= RST_ZERO_HIGH;
         ticks_ff.zero_low  <= RST_ZERO_LOW;
         ticks_ff.latch     <= RST_LATCH;
      end else begin
         divisor_ff <= divisor_in;
         ticks_ff   <= ticks_in;
      end
   end

   // Input stage: one word sits here while its lanes divide.
   assign lane_done   = {lane_stat[2].done, lane_stat[1].done, lane_stat[0].done};
   assign front_ready = front_valid_ff && ((front_op_ff == OP_LATCH) || (&lane_done));
   assign front_take  = front_ready && merge_stat.load_ready;
   assign req_ready   = !front_valid_ff || front_take;
   assign req_fire    = req_valid && req_ready;

   always_comb begin
      front_valid_in = front_valid_ff;
      front_op_in    = front_op_ff;
      if (req_fire) begin
         front_valid_in = 1'b1;
         front_op_in    = req_op;
      end else if (front_take) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
         front_op_ff    <= OP_PIXEL;
      end else begin
         front_valid_ff <= front_valid_in;
         front_op_ff    <= front_op_in;
      end
   end

   assign lane_ctl.start = req_fire && (req_op == OP_PIXEL);
   assign lane_ctl.take  = front_take;

   // Lane order matches the send order: green, red, blue.
   assign lane_in[0] = req_green;
   assign lane_in[1] = req_red;
   assign lane_in[2] = req_blue;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      rlbpe_div_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (lane_ctl),
         .dividend (lane_in[g]),
         .divisor  (divisor_ff),
         .stat     (lane_stat[g]),
         .quotient (lane_q[g])
      );
   end

   assign merge_word = {lane_q[0], lane_q[1], lane_q[2]};

   rlbpe_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (front_take),
      .load_op        (front_op_ff),
      .load_word      (merge_word),
      .ticks          (ticks_ff),
      .stat           (merge_stat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_high_ticks (rsp_high_ticks),
      .rsp_low_ticks  (rsp_low_ticks),
      .rsp_last       (rsp_last)
   );

   // The three lanes run in lockstep on every pixel word.
   `RLBPE_ASSERT_SAME(a_lanes_lockstep, clock, reset, front_valid_ff && (front_op_ff == OP_PIXEL), (lane_done == '0) || (lane_done == '1))
   // An active serializer always has pulses left to send.
   `RLBPE_ASSERT_SAME(a_left_nonzero, clock, reset, merge_stat.active, merge_stat.left != '0)
   // A word handed to the serializer makes it active in the next cycle.
   `RLBPE_ASSERT_NEXT(a_load_active, clock, reset, front_take, merge_stat.active)
   // Lanes are idle whenever the input stage is empty.
   `RLBPE_ASSERT_SAME(a_lanes_idle, clock, reset, !front_valid_ff, lane_stat[0].idle && lane_stat[1].idle && lane_stat[2].idle)

endmodule
